### rtl/core/asw_pkg.sv
// Shared types, codes and widths of the ARQ send window.
`timescale 1ns / 1ps

package asw_pkg;

   // Default window size, in sequence slots.
   localparam int WINDOW_SLOTS_DEF = 16;

   // Fixed field widths of the request and response transfers.
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COS_W    = 8;
   localparam int LEN_W    = 16;
   localparam int SEQ_W    = 4;

   // Command codes of a request transfer.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_POLL  = 2'd1,
      CMD_ACK   = 2'd2,
      CMD_START = 2'd3
   } cmd_type;

   // Status codes of a response transfer.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD_SEQ = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   // Write request from the control logic to the slot memories.
   typedef struct packed {
      logic             meta_we;
      logic             offset_we;
      logic [COS_W-1:0] cos;
      logic [LEN_W-1:0] length;
      logic [LEN_W-1:0] offset;
   } slot_wr_type;

endpackage

### rtl/core/asw_slot_mem.sv
// Slot memories of the send window: class and length, and the send offset.
`timescale 1ns / 1ps

module asw_slot_mem
   import asw_pkg::*;
#(
   parameter int DEPTH  = WINDOW_SLOTS_DEF,
   parameter int ADDR_W = $clog2(WINDOW_SLOTS_DEF)
) (
   input  logic              clock,
   input  slot_wr_type       wr,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [COS_W-1:0]  rd_cos,
   output logic [LEN_W-1:0]  rd_length,
   output logic [LEN_W-1:0]  rd_offset
);

   logic [COS_W+LEN_W-1:0] meta_mem [DEPTH];
   logic [LEN_W-1:0]       off_mem  [DEPTH];

   logic [COS_W+LEN_W-1:0] meta_rd_ff;
   logic [LEN_W-1:0]       off_rd_ff;

   // Class and length are written once per put; the offset also by each poll.
   always_ff @(posedge clock) begin
      if (wr.meta_we) begin
         meta_mem[wr_addr] <= {wr.cos, wr.length};
      end
      if (wr.offset_we) begin
         off_mem[wr_addr] <= wr.offset;
      end
      meta_rd_ff <= meta_mem[rd_addr];
      off_rd_ff  <= off_mem[rd_addr];
   end

   assign rd_cos    = meta_rd_ff[COS_W+LEN_W-1:LEN_W];
   assign rd_length = meta_rd_ff[LEN_W-1:0];
   assign rd_offset = off_rd_ff;

endmodule

### rtl/core/arq_send_window_unit.sv
// Top level of the selective-repeat send window with fragmenting send polls.
//
//   Port group   Direction  Transfer
//   start/req_*  in         command: accepted when start is high and busy is low
//   rsp_*        out        one response per command, rsp_valid high for one cycle
//
// Put and set-start: the response is registered in the put or start state.
// Send poll: a wait state for the registered read of the slot memories, then the
// execute state registers the response. Ack: an ack outside the window answers
// from the check state, as a put does; a valid ack marks its slot, then the ack
// pointer slides over the acked flags, one slot per cycle, before it answers.
// busy is low again in the cycle the response strobes, so the next command may
// be accepted then. Synchronous reset empties the window and sets all pointers
// to zero. The receiver of responses cannot stall the block.
`timescale 1ns / 1ps

module arq_send_window_unit
   import asw_pkg::*;
#(
   parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [COS_W-1:0]    req_cos,
   input  logic [LEN_W-1:0]    req_payload_len,
   input  logic [LEN_W-1:0]    req_avail_bytes,
   input  logic [SEQ_W-1:0]    req_seq_arg,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SEQ_W-1:0]    rsp_seq,
   output logic [COS_W-1:0]    rsp_out_cos,
   output logic                rsp_is_first,
   output logic                rsp_is_last,
   output logic [LEN_W-1:0]    rsp_frag_len,
   output logic [LEN_W-1:0]    rsp_frag_offset,
   output logic [LEN_W-1:0]    rsp_avail_left
);

   localparam int PTR_W  = $clog2(WINDOW_SLOTS);
   localparam int CNT_W  = PTR_W + 1;
   localparam int FREE_W = $clog2(WINDOW_SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUT,
      S_POLL_RD,
      S_POLL_EXEC,
      S_ACK_CHECK,
      S_ACK_SLIDE,
      S_START
   } state_type;

   state_type               state_ff, state_in;
   logic [COS_W-1:0]        cos_ff, cos_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        avail_ff, avail_in;
   logic [SEQ_W-1:0]        arg_ff, arg_in;
   logic [PTR_W-1:0]        put_ptr_ff, put_ptr_in;
   logic [PTR_W-1:0]        send_ptr_ff, send_ptr_in;
   logic [PTR_W-1:0]        ack_ptr_ff, ack_ptr_in;
   logic [FREE_W-1:0]       free_ff, free_in;
   logic [WINDOW_SLOTS-1:0] valid_ff, valid_in;
   logic [WINDOW_SLOTS-1:0] acked_ff, acked_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [SEQ_W-1:0]        rsp_seq_ff, rsp_seq_in;
   logic [COS_W-1:0]        rsp_cos_ff, rsp_cos_in;
   logic                    rsp_first_ff, rsp_first_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]        rsp_flen_ff, rsp_flen_in;
   logic [LEN_W-1:0]        rsp_foff_ff, rsp_foff_in;
   logic [LEN_W-1:0]        rsp_left_ff, rsp_left_in;

   slot_wr_type             slot_wr;
   logic [PTR_W-1:0]        slot_wr_addr;
   logic [COS_W-1:0]        slot_cos;
   logic [LEN_W-1:0]        slot_length;
   logic [LEN_W-1:0]        slot_offset;

   logic [LEN_W-1:0]        remaining;
   logic                    fits;
   logic [PTR_W-1:0]        arg_ptr;
   logic                    arg_in_range;
   logic [CNT_W-1:0]        span;
   logic [CNT_W-1:0]        arg_gap;
   logic [SEQ_W-1:0]        start_pos;

   // Slot memories, always read at the send pointer.
   asw_slot_mem #(
      .DEPTH  (WINDOW_SLOTS),
      .ADDR_W (PTR_W)
   ) u_slot_mem (
      .clock     (clock),
      .wr        (slot_wr),
      .wr_addr   (slot_wr_addr),
      .rd_addr   (send_ptr_ff),
      .rd_cos    (slot_cos),
      .rd_length (slot_length),
      .rd_offset (slot_offset)
   );

   // Next pointer around the circular sequence space.
   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (32'(p) == WINDOW_SLOTS - 1) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // Fragment arithmetic of a send poll.
   assign remaining = slot_length - slot_offset;
   assign fits      = (remaining <= avail_ff);

   // Ack window test: the sequence must lie from the ack pointer up to, but not including, the send pointer.
   assign arg_ptr      = PTR_W'(arg_ff);
   assign arg_in_range = (32'(arg_ff) < WINDOW_SLOTS);
   assign span = (send_ptr_ff >= ack_ptr_ff)
               ? CNT_W'(send_ptr_ff) - CNT_W'(ack_ptr_ff)
               : CNT_W'(send_ptr_ff) + CNT_W'(WINDOW_SLOTS) - CNT_W'(ack_ptr_ff);
   assign arg_gap = (arg_ptr >= ack_ptr_ff)
                  ? CNT_W'(arg_ptr) - CNT_W'(ack_ptr_ff)
                  : CNT_W'(arg_ptr) + CNT_W'(WINDOW_SLOTS) - CNT_W'(ack_ptr_ff);

   // New start position wrapped into the window; the argument is at most four bits.
   always_comb begin
      start_pos = arg_ff;
      for (int i = 0; i < 8; i++) begin
         if (32'(start_pos) >= WINDOW_SLOTS) begin
            start_pos = start_pos - SEQ_W'(WINDOW_SLOTS);
         end
      end
   end

   // Command sequencer: next state, window bookkeeping and the response.
   always_comb begin
      state_in      = state_ff;
      cos_in        = cos_ff;
      len_in        = len_ff;
      avail_in      = avail_ff;
      arg_in        = arg_ff;
      put_ptr_in    = put_ptr_ff;
      send_ptr_in   = send_ptr_ff;
      ack_ptr_in    = ack_ptr_ff;
      free_in       = free_ff;
      valid_in      = valid_ff;
      acked_in      = acked_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_seq_in    = '0;
      rsp_cos_in    = '0;
      rsp_first_in  = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_flen_in   = '0;
      rsp_foff_in   = '0;
      rsp_left_in   = '0;
      slot_wr       = '0;
      slot_wr_addr  = put_ptr_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cos_in   = req_cos;
               len_in   = req_payload_len;
               avail_in = req_avail_bytes;
               arg_in   = req_seq_arg;
               case (cmd_type'(req_cmd))
                  CMD_PUT:   state_in = S_PUT;
                  CMD_POLL:  state_in = S_POLL_RD;
                  CMD_ACK:   state_in = S_ACK_CHECK;
                  CMD_START: state_in = S_START;
                  default:   state_in = S_IDLE;
               endcase
            end
         end

         S_PUT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (free_ff == '0) begin
               rsp_status_in = ST_FULL;
            end else begin
               slot_wr.meta_we      = 1'b1;
               slot_wr.offset_we    = 1'b1;
               slot_wr.cos          = cos_ff;
               slot_wr.length       = len_ff;
               slot_wr.offset       = '0;
               valid_in[put_ptr_ff] = 1'b1;
               acked_in[put_ptr_ff] = 1'b0;
               rsp_seq_in           = SEQ_W'(put_ptr_ff);
               put_ptr_in           = wrap_next(put_ptr_ff);
               free_in              = free_ff - FREE_W'(1);
            end
         end

         // Wait state for the registered read at the send pointer.
         S_POLL_RD: begin
            state_in = S_POLL_EXEC;
         end

         S_POLL_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            slot_wr_addr = send_ptr_ff;
            if (!valid_ff[send_ptr_ff] || 32'(free_ff) >= WINDOW_SLOTS) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_seq_in        = SEQ_W'(send_ptr_ff);
               rsp_cos_in        = slot_cos;
               rsp_first_in      = (slot_offset == '0);
               slot_wr.offset_we = 1'b1;
               if (fits) begin
                  // The rest of the item goes out as the last fragment.
                  slot_wr.offset = slot_length;
                  rsp_last_in    = 1'b1;
                  rsp_flen_in    = remaining;
                  rsp_foff_in    = slot_length;
                  rsp_left_in    = avail_ff - remaining;
                  send_ptr_in    = wrap_next(send_ptr_ff);
                  free_in        = free_ff + FREE_W'(1);
               end else begin
                  slot_wr.offset = slot_offset + avail_ff;
                  rsp_flen_in    = avail_ff;
                  rsp_foff_in    = slot_offset + avail_ff;
               end
            end
         end

         S_ACK_CHECK: begin
            if (!arg_in_range || arg_gap >= span) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_BAD_SEQ;
               state_in      = S_IDLE;
            end else begin
               acked_in[arg_ptr] = 1'b1;
               state_in          = S_ACK_SLIDE;
            end
         end

         // Retire acknowledged slots one per cycle, never past the send pointer.
         S_ACK_SLIDE: begin
            if (ack_ptr_ff != send_ptr_ff && acked_ff[ack_ptr_ff]) begin
               valid_in[ack_ptr_ff] = 1'b0;
               acked_in[ack_ptr_ff] = 1'b0;
               ack_ptr_in           = wrap_next(ack_ptr_ff);
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_START: begin
            put_ptr_in   = PTR_W'(start_pos);
            send_ptr_in  = PTR_W'(start_pos);
            ack_ptr_in   = PTR_W'(start_pos);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, window registers and the registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cos_ff        <= '0;
         len_ff        <= '0;
         avail_ff      <= '0;
         arg_ff        <= '0;
         put_ptr_ff    <= '0;
         send_ptr_ff   <= '0;
         ack_ptr_ff    <= '0;
         free_ff       <= FREE_W'(WINDOW_SLOTS);
         valid_ff      <= '0;
         acked_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_seq_ff    <= '0;
         rsp_cos_ff    <= '0;
         rsp_first_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         rsp_flen_ff   <= '0;
         rsp_foff_ff   <= '0;
         rsp_left_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         cos_ff        <= cos_in;
         len_ff        <= len_in;
         avail_ff      <= avail_in;
         arg_ff        <= arg_in;
         put_ptr_ff    <= put_ptr_in;
         send_ptr_ff   <= send_ptr_in;
         ack_ptr_ff    <= ack_ptr_in;
         free_ff       <= free_in;
         valid_ff      <= valid_in;
         acked_ff      <= acked_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_seq_ff    <= rsp_seq_in;
         rsp_cos_ff    <= rsp_cos_in;
         rsp_first_ff  <= rsp_first_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_flen_ff   <= rsp_flen_in;
         rsp_foff_ff   <= rsp_foff_in;
         rsp_left_ff   <= rsp_left_in;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_seq         = rsp_seq_ff;
   assign rsp_out_cos     = rsp_cos_ff;
   assign rsp_is_first    = rsp_first_ff;
   assign rsp_is_last     = rsp_last_ff;
   assign rsp_frag_len    = rsp_flen_ff;
   assign rsp_frag_offset = rsp_foff_ff;
   assign rsp_avail_left  = rsp_left_ff;

   // A response only ever follows a cycle in which a command was in progress.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a command in progress");

   // The count of free slots never exceeds the window size.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      32'(free_ff) <= WINDOW_SLOTS)
      else $error("free slot count above window size");

   // An accepted command keeps the block busy and no response in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("command accepted without taking the block busy");

   // A full report only when no slot was free.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> ($past(free_ff) == '0))
      else $error("window full reported with free slots");

   // The ack slide ends as soon as it reaches the send pointer.
   a_slide_stop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACK_SLIDE && ack_ptr_ff == send_ptr_ff) |=> rsp_valid)
      else $error("ack slide ran past the send pointer");

endmodule
